// ----- sv/fit_strategy_segment_allocator_assert.svh -----
// Assertion macros for the segment allocator checker.
// Used by the bound checker only; no other dependencies.
`ifndef FIT_STRATEGY_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIT_STRATEGY_SEGMENT_ALLOCATOR_ASSERT_SVH
// implication checked every clock outside reset
`define FSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsa check failed");
// next-cycle implication checked every clock outside reset
`define FSA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsa check failed");
`endif

// ----- sv/fsa_pkg.sv -----
// Package for the segment allocator: field widths, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package fsa_pkg;
    localparam int unsigned OFS_W = 16;
    localparam int unsigned LEN_W = 17;
    localparam int unsigned CNT_W = 7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] MODE_BEST  = 2'd0;
    localparam logic [1:0] MODE_WORST = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             taken;
    } seg_t;

    typedef struct packed {
        logic             action;
        logic [LEN_W-1:0] request_bytes;
        logic [OFS_W-1:0] release_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] granted_offset;
        logic [LEN_W-1:0] free_total;
        logic [CNT_W-1:0] hole_count;
        logic [LEN_W-1:0] largest_hole;
    } rsp_t;
endpackage

// ----- sv/fsa_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
interface fsa_req_if;
    logic                valid;
    logic                ready;
    fsa_pkg::req_t       payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fsa_rsp_if;
    logic                valid;
    logic                ready;
    fsa_pkg::rsp_t       payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fsa_cfg_if;
    logic                valid;
    logic                ready;
    logic                index;
    logic [16:0]         data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/fsa_seg_ram.sv -----
// Segment table memory: one write port, one registered read port.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_seg_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW = 6
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  fsa_pkg::seg_t  wdata,
    input  logic [AW-1:0]  raddr,
    output fsa_pkg::seg_t  rdata
);
    import fsa_pkg::*;
    seg_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/fit_strategy_segment_allocator.sv -----
// Segment allocator top level: sequencer around the segment table memory.
// Depends on fsa_pkg, fsa_if and fsa_seg_ram.
//
// Usage:
//  req channel carries action, request_bytes, release_offset; rsp channel
//  returns status, granted_offset, free_total, hole_count, largest_hole; one
//  result per request. cfg channel writes fit_mode (index 0) and pool_bytes
//  (index 1); a pool_bytes write reinitialises the table to one free segment.
//  Requests are processed one at a time through a single memory read port
//  with a registered read. Each request runs a search pass over the entries,
//  then decides and fetches the chosen entry; a shift pass moves entries
//  for a split or merge; a statistics pass walks the table, and then the
//  result register is loaded. The memory read port sets the pace.
//  Reset: the state after reset writes entry zero as a free segment of the lesser of
//  POOL_BYTES and 65536; fit mode best fit, cursor zero.
//  The result sits in an output register. While the receiver stalls it
//  holds; the next request is still taken and processed but waits in its
//  last step until the register is free.
`timescale 1ns / 1ps
module fit_strategy_segment_allocator #(
    parameter int unsigned POOL_BYTES   = 65536,
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input logic        clk,
    input logic        rst_n,
    fsa_req_if.sink    req,
    fsa_rsp_if.source  rsp,
    fsa_cfg_if.sink    cfg
);
    import fsa_pkg::*;

    localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned POOL_MAX = (POOL_BYTES > 65536) ? 65536 : POOL_BYTES;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_RDPICK = 4'd3;
    localparam logic [3:0] S_PICK   = 4'd4;
    localparam logic [3:0] S_SHUP   = 4'd5;
    localparam logic [3:0] S_SPLIT  = 4'd6;
    localparam logic [3:0] S_FRD    = 4'd7;
    localparam logic [3:0] S_FNB    = 4'd8;
    localparam logic [3:0] S_SHDN   = 4'd9;
    localparam logic [3:0] S_STATS  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_RMW    = 4'd12;
    localparam logic [3:0] S_INIT   = 4'd13;

    logic [3:0]       state_reg;
    logic [1:0]       mode_reg;
    logic [LEN_W-1:0] pool_reg;
    logic [CW-1:0]    cnt_reg;
    logic [AW-1:0]    cur_reg;
    req_t             rq_reg;

    // walk control
    logic [CW-1:0]    idx_reg;        // address issued last cycle
    logic             rv_reg;         // read data valid for entry idx_reg
    logic [CW-1:0]    steps_reg;      // next-fit entries examined
    logic             found_reg;
    logic [AW-1:0]    best_reg;
    logic [LEN_W-1:0] best_len_reg;
    seg_t             pick_reg;       // chosen / freed entry
    seg_t             prev_reg;       // lower neighbour
    logic             prev_free_reg;
    logic [AW-1:0]    tgt_reg;        // merge base or split remainder index
    logic [CW-1:0]    rm_reg;         // entries to remove in merge
    seg_t             carry_reg;      // entry written at tgt_reg: split remainder or merged segment
    logic [1:0]       st_reg;
    logic [OFS_W-1:0] gr_reg;
    logic [LEN_W-1:0] tot_reg, lrg_reg;
    logic [CNT_W-1:0] hol_reg;
    rsp_t             out_reg;
    logic             ov_reg;

    // memory port
    logic          we;
    logic [AW-1:0] waddr, raddr;
    seg_t          wdata, rdata;

    fsa_seg_ram #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // register writes are only taken while idle
    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign rsp.valid = ov_reg;
    assign rsp.payload = out_reg;

    logic [LEN_W-1:0] cfg_pool;
    always_comb
    begin
        if (cfg.data == '0)
            cfg_pool = LEN_W'(1);
        else if ({15'd0, cfg.data} > 32'(POOL_MAX))
            cfg_pool = LEN_W'(POOL_MAX);
        else
            cfg_pool = cfg.data;
    end

    // next-fit start index wraps to zero past the end
    logic [AW-1:0] nf_start;
    assign nf_start = ({{(CW-AW){1'b0}}, cur_reg} < cnt_reg) ? cur_reg : '0;

    logic [CW-1:0] idx_inc;
    assign idx_inc = idx_reg + CW'(1);

    logic [CW-1:0] nf_idx;
    assign nf_idx = (idx_inc >= cnt_reg) ? '0 : idx_inc;

    logic scan_next;
    assign scan_next = (rq_reg.action == ACT_ALLOC) && (mode_reg == MODE_NEXT);

    // next-fit predicate on current read data
    logic fits;
    assign fits = !rdata.taken && (rdata.length >= rq_reg.request_bytes);

    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                wdata.length = pool_reg;
            end
            S_IDLE:
            begin
                if (cfg.valid && cfg.index == REG_POOL_BYTES)
                begin
                    we = 1'b1;
                    wdata.length = cfg_pool;
                end
                else if (req.valid)
                begin
                    raddr = (req.payload.action == ACT_ALLOC && mode_reg == MODE_NEXT)
                        ? nf_start : '0;
                end
            end
            S_SCAN:    raddr = scan_next ? nf_idx[AW-1:0] : idx_inc[AW-1:0];
            S_RDPICK:  raddr = best_reg;
            S_SHUP:    raddr = idx_reg[AW-1:0];
            S_SPLIT:
            begin
                we = 1'b1;
                waddr = best_reg;
                wdata = '{start: pick_reg.start, length: rq_reg.request_bytes, taken: 1'b1};
            end
            S_RMW:
            begin
                we = 1'b1;
                waddr = best_reg;
                wdata = '{start: pick_reg.start, length: pick_reg.length, taken: 1'b1};
            end
            S_SHDN:    raddr = idx_reg[AW-1:0];
            S_STATS:   raddr = rv_reg ? idx_inc[AW-1:0] : idx_reg[AW-1:0];
            default:   raddr = idx_reg[AW-1:0];
        endcase
        // shift writes and the split/merge entry write, issued from the sequential block's decisions
        if (state_reg == S_SHUP && rv_reg)
        begin
            we = 1'b1;
            waddr = AW'(idx_reg + CW'(1));
            wdata = rdata;
        end
        if (state_reg == S_SHDN && rv_reg)
        begin
            we = 1'b1;
            waddr = AW'(idx_reg - rm_reg);
            wdata = rdata;
        end
        if (state_reg == S_FNB)
        begin
            we = 1'b1;
            waddr = tgt_reg;
            wdata = carry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            mode_reg  <= MODE_BEST;
            pool_reg  <= LEN_W'(POOL_MAX);
            cnt_reg   <= CW'(1);
            cur_reg   <= '0;
            ov_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (ov_reg && rsp.ready && state_reg != S_OUT)
                ov_reg <= 1'b0;
            case (state_reg)
                // entry zero becomes one free segment after reset
                S_INIT:    state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (cfg.valid)
                    begin
                        if (cfg.index == REG_FIT_MODE)
                            mode_reg <= cfg.data[1:0];
                        else
                        begin
                            pool_reg <= cfg_pool;
                            cnt_reg <= CW'(1);
                            cur_reg <= '0;
                        end
                    end
                    else if (req.valid)
                    begin
                        rq_reg <= req.payload;
                        idx_reg <= (req.payload.action == ACT_ALLOC
                            && mode_reg == MODE_NEXT) ? {{(CW-AW){1'b0}}, nf_start} : '0;
                        steps_reg <= '0;
                        found_reg <= 1'b0;
                        best_reg <= '0;
                        prev_free_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                // one entry per cycle: fit search or offset lookup
                S_SCAN:
                begin
                    if (rq_reg.action == ACT_FREE)
                    begin
                        idx_reg <= idx_inc;
                        if (rdata.start == rq_reg.release_offset)
                        begin
                            best_reg <= idx_reg[AW-1:0];
                            pick_reg <= rdata;
                            // a free segment at that offset is not found
                            state_reg <= rdata.taken ? S_FRD : S_DECIDE;
                        end
                        else
                        begin
                            prev_reg <= rdata;
                            prev_free_reg <= !rdata.taken;
                            if (idx_inc >= cnt_reg)
                                state_reg <= S_DECIDE;
                        end
                    end
                    else if (mode_reg == MODE_NEXT)
                    begin
                        steps_reg <= steps_reg + CW'(1);
                        idx_reg <= nf_idx;
                        if (fits)
                        begin
                            found_reg <= 1'b1;
                            best_reg <= idx_reg[AW-1:0];
                            state_reg <= S_DECIDE;
                        end
                        else if (steps_reg + CW'(1) >= cnt_reg)
                            state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        if (!rdata.taken && (mode_reg == MODE_BEST
                            ? (rdata.length >= rq_reg.request_bytes
                               && (!found_reg || rdata.length < best_len_reg))
                            : (!found_reg || rdata.length > best_len_reg)))
                        begin
                            found_reg <= 1'b1;
                            best_reg <= idx_reg[AW-1:0];
                            best_len_reg <= rdata.length;
                        end
                        if (idx_inc >= cnt_reg)
                            state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    gr_reg <= '0;
                    if (rq_reg.action == ACT_FREE)
                    begin
                        st_reg <= ST_NOT_FOUND;
                        state_reg <= S_STATS;
                        idx_reg <= '0;
                    end
                    else if (rq_reg.request_bytes == '0 || !found_reg
                        || mode_reg == 2'd3
                        || (mode_reg == MODE_WORST && best_len_reg < rq_reg.request_bytes))
                    begin
                        st_reg <= ST_NO_FIT;
                        state_reg <= S_STATS;
                        idx_reg <= '0;
                    end
                    else
                        state_reg <= S_RDPICK;
                end
                S_RDPICK:  state_reg <= S_PICK;
                S_PICK:
                begin
                    pick_reg <= rdata;
                    if (rdata.length > rq_reg.request_bytes)
                    begin
                        if (cnt_reg >= CW'(MAX_SEGMENTS))
                        begin
                            st_reg <= ST_FULL;
                            gr_reg <= '0;
                            state_reg <= S_STATS;
                            idx_reg <= '0;
                        end
                        else
                        begin
                            // move entries above the pick up by one, top first
                            idx_reg <= cnt_reg - CW'(1);
                            rv_reg <= 1'b0;
                            state_reg <= S_SHUP;
                        end
                    end
                    else
                    begin
                        st_reg <= ST_OK;
                        gr_reg <= rdata.start;
                        cur_reg <= ({{(CW-AW){1'b0}}, best_reg} + CW'(1) < cnt_reg)
                            ? AW'(best_reg + AW'(1)) : '0;
                        state_reg <= S_RMW;
                    end
                end
                S_RMW:
                begin
                    state_reg <= S_STATS;
                    idx_reg <= '0;
                end
                // read idx, write it to idx+1 next cycle, walking downwards
                S_SHUP:
                begin
                    if (!rv_reg)
                    begin
                        if (idx_reg <= {{(CW-AW){1'b0}}, best_reg})
                            state_reg <= S_SPLIT;
                        else
                            rv_reg <= 1'b1;
                    end
                    else
                    begin
                        rv_reg <= 1'b0;
                        idx_reg <= idx_reg - CW'(1);
                    end
                end
                S_SPLIT:
                begin
                    carry_reg <= '{start: pick_reg.start + rq_reg.request_bytes[OFS_W-1:0],
                                   length: pick_reg.length - rq_reg.request_bytes,
                                   taken: 1'b0};
                    tgt_reg <= AW'(best_reg + AW'(1));
                    cnt_reg <= cnt_reg + CW'(1);
                    cur_reg <= AW'(best_reg + AW'(1));
                    st_reg <= ST_OK;
                    gr_reg <= pick_reg.start;
                    rm_reg <= '0;
                    state_reg <= S_FNB;
                end
                // free: lower neighbour known, rdata holds entry best+1
                S_FRD:
                begin
                    begin : merge_plan
                        logic up_free;
                        logic dn_free;
                        logic [LEN_W-1:0] len;
                        up_free = ({{(CW-AW){1'b0}}, best_reg} + CW'(1) < cnt_reg)
                            && !rdata.taken;
                        dn_free = (best_reg != '0) && prev_free_reg;
                        len = pick_reg.length + (up_free ? rdata.length : '0)
                            + (dn_free ? prev_reg.length : '0);
                        tgt_reg <= dn_free ? AW'(best_reg - AW'(1)) : best_reg;
                        carry_reg <= '{start: dn_free ? prev_reg.start : pick_reg.start,
                                       length: len, taken: 1'b0};
                        rm_reg <= CW'(up_free) + CW'(dn_free);
                        cnt_reg <= cnt_reg - (CW'(up_free) + CW'(dn_free));
                        // cursor follows removed entries
                        if (dn_free && {{(CW-AW){1'b0}}, cur_reg} >= CW'(best_reg))
                        begin
                            if (up_free && {{(CW-AW){1'b0}}, cur_reg} >= CW'(best_reg) + CW'(1))
                                cur_reg <= AW'(cur_reg - AW'(2));
                            else
                                cur_reg <= AW'(cur_reg - AW'(1));
                        end
                        else if (up_free && {{(CW-AW){1'b0}}, cur_reg} >= CW'(best_reg) + CW'(1))
                            cur_reg <= AW'(cur_reg - AW'(1));
                        idx_reg <= CW'(best_reg) + CW'(1) + CW'(up_free);
                    end
                    st_reg <= ST_OK;
                    gr_reg <= '0;
                    state_reg <= S_FNB;
                end
                S_FNB:
                begin
                    if (rm_reg == '0)
                    begin
                        state_reg <= S_STATS;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        rv_reg <= 1'b0;
                        state_reg <= S_SHDN;
                    end
                end
                // read idx, write it rm places lower next cycle
                S_SHDN:
                begin
                    if (!rv_reg)
                    begin
                        if (idx_reg >= cnt_reg + rm_reg)
                        begin
                            state_reg <= S_STATS;
                            idx_reg <= '0;
                        end
                        else
                            rv_reg <= 1'b1;
                    end
                    else
                    begin
                        rv_reg <= 1'b0;
                        idx_reg <= idx_inc;
                    end
                end
                // accumulate free statistics, one entry per cycle
                S_STATS:
                begin
                    if (!rv_reg)
                    begin
                        rv_reg <= 1'b1;
                        tot_reg <= '0;
                        hol_reg <= '0;
                        lrg_reg <= '0;
                    end
                    else
                    begin
                        if (!rdata.taken)
                        begin
                            tot_reg <= tot_reg + rdata.length;
                            hol_reg <= hol_reg + CNT_W'(1);
                            if (rdata.length > lrg_reg)
                                lrg_reg <= rdata.length;
                        end
                        idx_reg <= idx_inc;
                        if (idx_inc >= cnt_reg)
                        begin
                            rv_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || rsp.ready)
                    begin
                        out_reg <= '{status: st_reg, granted_offset: gr_reg,
                                     free_total: tot_reg, hole_count: hol_reg,
                                     largest_hole: lrg_reg};
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/fsa_checker.sv -----
// Port checker for the segment allocator, bound to the top level.
// Depends on fsa_pkg, fsa_if and the assertion macro header.
`timescale 1ns / 1ps
`include "fit_strategy_segment_allocator_assert.svh"
module fsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        cfg_ready,
    input fsa_pkg::rsp_t rsp_payload
);
    import fsa_pkg::*;
    `FSA_ASSERT_IMP(a_grant_zero_on_fail, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.granted_offset == '0)
    `FSA_ASSERT_IMP(a_holes_vs_largest, rsp_valid && rsp_payload.hole_count == '0, rsp_payload.largest_hole == '0 && rsp_payload.free_total == '0)
    `FSA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready && !cfg_ready)
    `FSA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
endmodule

bind fit_strategy_segment_allocator fsa_checker u_fsa_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .cfg_ready(cfg.ready), .rsp_payload(rsp.payload)
);

// ----- tb/fit_strategy_segment_allocator_tb.sv -----
// Testbench for the segment allocator: directed and random requests checked
// against a scoreboard that keeps its own copy of the segment table.
// Depends on fsa_pkg, fsa_if and fit_strategy_segment_allocator.
`timescale 1ns / 1ps
import fsa_pkg::*;

class alloc_scoreboard;
    localparam int unsigned SEGS = 64;
    localparam logic [LEN_W-1:0] POOL_MAX = 17'd65536;

    logic [1:0]       fit_mode;
    logic [LEN_W-1:0] pool_size;
    logic [OFS_W-1:0] seg_base [SEGS];
    logic [LEN_W-1:0] seg_len [SEGS];
    logic             seg_used [SEGS];
    int unsigned      seg_num;
    int unsigned      cursor;
    rsp_t             pending_rsp [$];
    int unsigned      errors;

    function new();
        errors = 0;
        fit_mode = MODE_BEST;
        pool_size = POOL_MAX;
        clear_table();
    endfunction

    function void clear_table();
        for (int i = 0; i < SEGS; i++)
        begin
            seg_base[i] = '0;
            seg_len[i] = '0;
            seg_used[i] = 1'b0;
        end
        seg_len[0] = pool_size;
        seg_num = 1;
        cursor = 0;
    endfunction

    // register write as the block applies it
    function void write_reg(logic idx, logic [16:0] data);
        if (idx == REG_FIT_MODE)
            fit_mode = data[1:0];
        else
        begin
            if (data == 0)
                pool_size = 17'd1;
            else if (data > POOL_MAX)
                pool_size = POOL_MAX;
            else
                pool_size = data;
            clear_table();
        end
    endfunction

    // fold entry r into entry r-1
    function void merge_into_lower(int unsigned r);
        seg_len[r-1] += seg_len[r];
        for (int unsigned k = r; k + 1 < seg_num; k++)
        begin
            seg_base[k] = seg_base[k+1];
            seg_len[k] = seg_len[k+1];
            seg_used[k] = seg_used[k+1];
        end
        seg_num--;
        if (cursor >= r)
            cursor--;
    endfunction

    function bit pick_hole(logic [LEN_W-1:0] want, output int unsigned pick);
        int unsigned i;
        bit found;
        found = 0;
        pick = 0;
        if (fit_mode == MODE_BEST || fit_mode == MODE_WORST)
        begin
            for (i = 0; i < seg_num; i++)
            begin
                if (seg_used[i])
                    continue;
                if (fit_mode == MODE_BEST)
                begin
                    if (seg_len[i] >= want && (!found || seg_len[i] < seg_len[pick]))
                    begin
                        pick = i;
                        found = 1;
                    end
                end
                else if (!found || seg_len[i] > seg_len[pick])
                begin
                    pick = i;
                    found = 1;
                end
            end
            if (found && seg_len[pick] < want)
                found = 0;
        end
        else if (fit_mode == MODE_NEXT)
        begin
            i = (cursor < seg_num) ? cursor : 0;
            for (int unsigned k = 0; k < seg_num; k++)
            begin
                if (!seg_used[i] && seg_len[i] >= want)
                begin
                    pick = i;
                    found = 1;
                    break;
                end
                i++;
                if (i >= seg_num)
                    i = 0;
            end
        end
        return found;
    endfunction

    function logic [1:0] do_alloc(logic [LEN_W-1:0] want, output logic [OFS_W-1:0] granted);
        int unsigned i;
        granted = '0;
        if (want == 0 || !pick_hole(want, i))
            return ST_NO_FIT;
        if (seg_len[i] > want)
        begin
            if (seg_num >= SEGS)
                return ST_FULL;
            for (int unsigned k = seg_num; k > i + 1; k--)
            begin
                seg_base[k] = seg_base[k-1];
                seg_len[k] = seg_len[k-1];
                seg_used[k] = seg_used[k-1];
            end
            seg_num++;
            seg_base[i+1] = seg_base[i] + want[OFS_W-1:0];
            seg_len[i+1] = seg_len[i] - want;
            seg_used[i+1] = 1'b0;
            seg_len[i] = want;
            cursor = i + 1;
        end
        else
            cursor = (i + 1 < seg_num) ? i + 1 : 0;
        seg_used[i] = 1'b1;
        granted = seg_base[i];
        return ST_OK;
    endfunction

    function logic [1:0] do_release(logic [OFS_W-1:0] ofs);
        int unsigned t;
        for (t = 0; t < seg_num; t++)
            if (seg_base[t] == ofs)
                break;
        if (t >= seg_num || !seg_used[t])
            return ST_NOT_FOUND;
        seg_used[t] = 1'b0;
        if (t > 0 && !seg_used[t-1])
        begin
            merge_into_lower(t);
            t--;
        end
        if (t + 1 < seg_num && !seg_used[t+1])
            merge_into_lower(t + 1);
        return ST_OK;
    endfunction

    // accepted request: update table, queue the expected result
    function void note_request(req_t r);
        rsp_t e;
        e = '0;
        if (r.action == ACT_ALLOC)
            e.status = do_alloc(r.request_bytes, e.granted_offset);
        else
            e.status = do_release(r.release_offset);
        for (int unsigned i = 0; i < seg_num; i++)
        begin
            if (seg_used[i])
                continue;
            e.free_total += seg_len[i];
            e.hole_count++;
            if (seg_len[i] > e.largest_hole)
                e.largest_hole = seg_len[i];
        end
        pending_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t got);
        rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result %p", got);
            return;
        end
        e = pending_rsp.pop_front();
        if (got.status !== e.status || got.granted_offset !== e.granted_offset ||
            got.free_total !== e.free_total || got.hole_count !== e.hole_count ||
            got.largest_hole !== e.largest_hole)
        begin
            errors++;
            if (errors <= 10)
                $display("result differs: expected %p got %p", e, got);
        end
    endfunction
endclass

module fit_strategy_segment_allocator_tb;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    longint cycles;
    int unsigned burst_left;
    int unsigned stall_phase;
    alloc_scoreboard sb;

    fsa_req_if req ();
    fsa_rsp_if rsp ();
    fsa_cfg_if cfg ();

    fit_strategy_segment_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // timeout guard
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fit_strategy_segment_allocator: mismatch");
            $finish;
        end
    end

    // receiver: checks each result under a stall pattern picked anew at random
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            sb.check_result(rsp.payload);
        if (cycles % 400 == 0)
            stall_phase <= $urandom_range(0, 3);
        case (stall_phase)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= ($urandom_range(0, 1) != 0);
            default: rsp.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // one transaction on the request channel, then maybe a gap
    task automatic send(req_t r);
        req.payload <= r;
        req.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(r);
        if (burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
        else
            burst_left--;
    endtask

    task automatic alloc_req(logic [LEN_W-1:0] n);
        req_t r;
        r = '0;
        r.action = ACT_ALLOC;
        r.request_bytes = n;
        r.release_offset = OFS_W'($urandom);
        send(r);
    endtask

    task automatic free_req(logic [OFS_W-1:0] ofs);
        req_t r;
        r = '0;
        r.action = ACT_FREE;
        r.release_offset = ofs;
        r.request_bytes = LEN_W'($urandom);
        send(r);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic idx, logic [16:0] data);
        drain();
        cfg.index <= idx;
        cfg.data <= data;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // random request shaped by the current pool size
    task automatic random_req();
        int unsigned sel;
        int unsigned n;
        logic [LEN_W-1:0] span;
        sel = $urandom_range(0, 99);
        span = sb.pool_size;
        if (sel < 55)
        begin
            if (sel < 3)
                alloc_req(LEN_W'($urandom_range(1, 65536)));
            else if (sel < 6)
                alloc_req(17'd1);
            else if (sel < 30)
                alloc_req(LEN_W'($urandom_range(1, (span / 64) + 1)));
            else
                alloc_req(LEN_W'($urandom_range(1, (span / 4) + 1)));
        end
        else if (sel < 90)
        begin
            // release a live segment where there is one
            n = 0;
            for (int unsigned i = 0; i < sb.seg_num; i++)
                if (sb.seg_used[i])
                    n++;
            if (n == 0)
                alloc_req(LEN_W'($urandom_range(1, (span / 8) + 1)));
            else
            begin
                n = $urandom_range(0, n - 1);
                for (int unsigned i = 0; i < sb.seg_num; i++)
                    if (sb.seg_used[i])
                    begin
                        if (n == 0)
                        begin
                            free_req(sb.seg_base[i]);
                            break;
                        end
                        n--;
                    end
            end
        end
        else if (sel < 95)
            free_req(sb.seg_base[$urandom_range(0, sb.seg_num - 1)]);
        else
            free_req(OFS_W'($urandom));
    endtask

    initial
    begin
        logic [16:0] pool;
        sb = new();
        burst_left = 0;
        stall_phase = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.payload = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_FIT_MODE;
        cfg.data = '0;
        rsp.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and error codes in best fit
        alloc_req(17'd0);
        alloc_req(17'd65536);
        alloc_req(17'd1);
        free_req(16'd0);
        free_req(16'd0);
        free_req(16'd12345);
        alloc_req(17'd100);
        alloc_req(17'd100);
        alloc_req(17'd100);
        alloc_req(17'd100);
        free_req(16'd0);
        free_req(16'd200);
        alloc_req(17'd50);
        free_req(16'd50);
        // worst fit with too small a hole, then a normal worst fit
        write_reg(REG_FIT_MODE, 17'(MODE_WORST));
        alloc_req(17'd65536);
        alloc_req(17'd30);
        // next fit wraps round from the cursor
        write_reg(REG_FIT_MODE, 17'(MODE_NEXT));
        alloc_req(17'd40);
        alloc_req(17'd60000);
        alloc_req(17'd100);
        // meaningless mode answers no fit
        write_reg(REG_FIT_MODE, 17'(MODE_UNUSED));
        alloc_req(17'd1);
        // pool size clamping at both ends
        write_reg(REG_POOL_BYTES, 17'd0);
        alloc_req(17'd1);
        alloc_req(17'd1);
        write_reg(REG_POOL_BYTES, 17'h1FFFF);
        alloc_req(17'd65536);
        free_req(16'hFFFF);

        // random phases over modes and pool sizes
        for (int p = 0; p < 10; p++)
        begin
            write_reg(REG_FIT_MODE, (p == 7) ? 17'(MODE_UNUSED) : 17'(p % 3));
            case (p % 5)
                0: pool = 17'd65536;
                1: pool = 17'($urandom_range(1, 8));
                2: pool = 17'($urandom_range(64, 4096));
                3: pool = 17'($urandom_range(1, 131071));
                default: pool = 17'($urandom_range(0, 65536));
            endcase
            write_reg(REG_POOL_BYTES, pool);
            for (int k = 0; k < 75; k++)
            begin
                if (p == 4 && k == 40)
                    drain();
                random_req();
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("fit_strategy_segment_allocator: match");
        else
            $display("fit_strategy_segment_allocator: mismatch");
        $finish;
    end
endmodule

// ----- fit_strategy_segment_allocator.f -----
+incdir+sv
sv/fsa_pkg.sv
sv/fsa_if.sv
sv/fsa_seg_ram.sv
sv/fit_strategy_segment_allocator.sv
sv/fsa_checker.sv
tb/fit_strategy_segment_allocator_tb.sv
